/* hw/rtl/abts_pkg.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// abts_pkg: shared types and codes for the array binary tree store
// Item kinds, status codes, datapath command codes and the command and
// status structs that join the controller and the datapath.
// ---------------------------------------------------------------------------
package abts_pkg;

   localparam logic [31:0] EMPTY_MARK = 32'hFFFF_FFFF;

   localparam logic [1:0] KIND_SET_ROOT = 2'd0;
   localparam logic [1:0] KIND_INSERT   = 2'd1;
   localparam logic [1:0] KIND_DELETE   = 2'd2;
   localparam logic [1:0] KIND_READ     = 2'd3;

   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_NOT_FOUND = 2'd1;
   localparam logic [1:0] ST_BLOCKED   = 2'd2;
   localparam logic [1:0] ST_NO_ROOM   = 2'd3;

   localparam logic [3:0] CAND_HOLD   = 4'd0;
   localparam logic [3:0] CAND_INC    = 4'd1;
   localparam logic [3:0] CAND_ROOT   = 4'd2;
   localparam logic [3:0] CAND_DOUBLE = 4'd3;
   localparam logic [3:0] CAND_HALF   = 4'd4;
   localparam logic [3:0] CAND_CHILD  = 4'd5;
   localparam logic [3:0] CAND_LEFT   = 4'd6;
   localparam logic [3:0] CAND_RIGHT  = 4'd7;
   localparam logic [3:0] CAND_READ   = 4'd8;

   localparam logic [1:0] WR_CLEAR  = 2'd0;
   localparam logic [1:0] WR_ROOT   = 2'd1;
   localparam logic [1:0] WR_CHILD  = 2'd2;
   localparam logic [1:0] WR_DELETE = 2'd3;

   localparam logic [2:0] RIDX_ZERO  = 3'd0;
   localparam logic [2:0] RIDX_ONE   = 3'd1;
   localparam logic [2:0] RIDX_CAND  = 3'd2;
   localparam logic [2:0] RIDX_FOUND = 3'd3;
   localparam logic [2:0] RIDX_READ  = 3'd4;

   localparam logic [1:0] RVAL_EMPTY = 2'd0;
   localparam logic [1:0] RVAL_NEW   = 2'd1;
   localparam logic [1:0] RVAL_KEY   = 2'd2;
   localparam logic [1:0] RVAL_RDATA = 2'd3;

   typedef struct packed {
      logic       load_item;
      logic [3:0] cand_op;
      logic       found_load;
      logic       left_load;
      logic       left_from_rd;
      logic       mem_rd;
      logic       mem_wr;
      logic [1:0] wr_sel;
      logic       res_load;
      logic [1:0] res_status;
      logic [2:0] res_idx_sel;
      logic [1:0] res_val_sel;
      logic       out_load;
   } abts_cmd_type;

   typedef struct packed {
      logic       cand_oor;
      logic       cand_is_one;
      logic       cand_odd;
      logic       clear_last;
      logic       rdata_empty;
      logic       rdata_match;
      logic       left_empty;
      logic       rd_oor;
      logic       out_busy;
      logic [1:0] kind;
   } abts_sts_type;

endpackage

/* hw/rtl/array_binary_tree_store.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// array_binary_tree_store: binary tree held in a slot store
// Root at slot 1, children of slot i at 2i and 2i+1, all-ones marks empty.
//
// req channel: one command per transfer; tuser carries the kind (set root,
// insert child, delete leaf, read slot), tdata the key, side, value, slot.
// rsp channel: exactly one result per command; tuser carries the status,
// tdata the slot index, the slot value and the empty flag.
// Commands run one at a time. Insert and delete walk the tree in preorder
// through the slot RAM: each slot inside the store is read and then
// compared (issue read, compare), since the single RAM read port has a
// registered output; a child slot beyond the store is skipped and the
// walk climbs back up one step at a time.
// Reset starts a clearing sweep over all STORE_DEPTH slots, one slot a
// cycle; req_tready stays low until it ends.
// The result sits in an output register. While the receiver stalls the
// next command is still taken and run; its result waits in a staging
// register and req_tready stays low until the output register frees.
// ---------------------------------------------------------------------------
module array_binary_tree_store import abts_pkg::*; #(
   parameter int STORE_DEPTH = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // kind[1:0]
   input  logic [1:0]  req_tuser,
   // search_key[31:0], child_side[32], insert_value[64:33], slot_index[72:65]
   input  logic [79:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // status[1:0]
   output logic [1:0]  rsp_tuser,
   // node_index[7:0], node_value[39:8], is_empty[40]
   output logic [47:0] rsp_tdata
);

   abts_cmd_type cmd;
   abts_sts_type sts;

   abts_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .sts       (sts),
      .cmd       (cmd)
   );

   abts_dp #(
      .STORE_DEPTH(STORE_DEPTH)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .sts       (sts),
      .req_tuser (req_tuser),
      .req_tdata (req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tuser (rsp_tuser),
      .rsp_tdata (rsp_tdata)
   );

`ifndef NO_ASSERTIONS
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> !(rsp_tvalid && !rsp_tready))
      else $error("result loaded over a stalled result");

   a_rsp_from_load: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(cmd.out_load))
      else $error("result shown without a load");

   a_write_when_busy: assert property (@(posedge clock) disable iff (reset)
      (cmd.mem_wr && cmd.wr_sel != WR_CLEAR) |-> !req_tready)
      else $error("slot write while idle");

   a_child_in_range: assert property (@(posedge clock) disable iff (reset)
      (cmd.mem_wr && cmd.wr_sel == WR_CHILD) |-> (!sts.cand_oor && !sts.cand_is_one))
      else $error("child write outside the store or at the root");
`endif

endmodule

/* hw/rtl/abts_ram.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// abts_ram: generic single-clock RAM
// One write port and one read port, read data registered.
// ---------------------------------------------------------------------------
module abts_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* hw/rtl/abts_dp.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// abts_dp: datapath of the array binary tree store
// Item registers, candidate slot register, slot store, result staging and
// the output register, all driven by controller commands.
// ---------------------------------------------------------------------------
module abts_dp import abts_pkg::*; #(
   parameter int STORE_DEPTH = 256
) (
   input  logic         clock,
   input  logic         reset,
   input  abts_cmd_type cmd,
   output abts_sts_type sts,
   input  logic [1:0]   req_tuser,
   input  logic [79:0]  req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [1:0]   rsp_tuser,
   output logic [47:0]  rsp_tdata
);

   localparam int IDX_W  = $clog2(STORE_DEPTH);
   localparam int SLOT_W = IDX_W + 1;

   logic [1:0]        kind_ff;
   logic [31:0]       key_ff;
   logic              side_ff;
   logic [31:0]       val_ff;
   logic [7:0]        rd_ff;
   logic [SLOT_W-1:0] cand_ff, cand_in;
   logic [IDX_W-1:0]  found_ff;
   logic              left_empty_ff;
   logic [1:0]        res_status_ff;
   logic [7:0]        res_idx_ff, res_idx_in;
   logic [31:0]       res_value_ff, res_value_in;
   logic              out_valid_ff;
   logic [1:0]        out_status_ff;
   logic [7:0]        out_idx_ff;
   logic [31:0]       out_value_ff;
   logic              out_empty_ff;

   logic              wr_en;
   logic [IDX_W-1:0]  wr_addr;
   logic [31:0]       wr_data;
   logic [31:0]       rd_data;

   always_comb begin
      unique case (cmd.cand_op)
         CAND_INC:    cand_in = cand_ff + SLOT_W'(1);
         CAND_ROOT:   cand_in = SLOT_W'(1);
         CAND_DOUBLE: cand_in = {cand_ff[IDX_W-1:0], 1'b0};
         CAND_HALF:   cand_in = cand_ff >> 1;
         CAND_CHILD:  cand_in = {cand_ff[IDX_W-1:0], side_ff};
         CAND_LEFT:   cand_in = {cand_ff[IDX_W-1:0], 1'b0};
         CAND_RIGHT:  cand_in = {found_ff, 1'b1};
         CAND_READ:   cand_in = SLOT_W'(rd_ff);
         default:     cand_in = cand_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cand_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         cand_ff <= cand_in;
         if (cmd.out_load) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_item) begin
         kind_ff <= req_tuser;
         key_ff  <= req_tdata[31:0];
         side_ff <= req_tdata[32];
         val_ff  <= req_tdata[64:33];
         rd_ff   <= req_tdata[72:65];
      end
      if (cmd.found_load) begin
         found_ff <= cand_ff[IDX_W-1:0];
      end
      if (cmd.left_load) begin
         left_empty_ff <= cmd.left_from_rd ? (rd_data == EMPTY_MARK) : 1'b1;
      end
      if (cmd.res_load) begin
         res_status_ff <= cmd.res_status;
         res_idx_ff    <= res_idx_in;
         res_value_ff  <= res_value_in;
      end
      if (cmd.out_load) begin
         out_status_ff <= res_status_ff;
         out_idx_ff    <= res_idx_ff;
         out_value_ff  <= res_value_ff;
         out_empty_ff  <= (res_value_ff == EMPTY_MARK);
      end
   end

   always_comb begin
      unique case (cmd.res_idx_sel)
         RIDX_ONE:   res_idx_in = 8'd1;
         RIDX_CAND:  res_idx_in = 8'(cand_ff);
         RIDX_FOUND: res_idx_in = 8'(found_ff);
         RIDX_READ:  res_idx_in = rd_ff;
         default:    res_idx_in = 8'd0;
      endcase
      unique case (cmd.res_val_sel)
         RVAL_NEW:   res_value_in = val_ff;
         RVAL_KEY:   res_value_in = key_ff;
         RVAL_RDATA: res_value_in = rd_data;
         default:    res_value_in = EMPTY_MARK;
      endcase
   end

   always_comb begin
      wr_en = cmd.mem_wr;
      unique case (cmd.wr_sel)
         WR_ROOT: begin
            wr_addr = IDX_W'(1);
            wr_data = val_ff;
         end
         WR_CHILD: begin
            wr_addr = cand_ff[IDX_W-1:0];
            wr_data = val_ff;
         end
         WR_DELETE: begin
            wr_addr = found_ff;
            wr_data = EMPTY_MARK;
         end
         default: begin
            wr_addr = cand_ff[IDX_W-1:0];
            wr_data = EMPTY_MARK;
         end
      endcase
   end

   abts_ram #(
      .WIDTH(32),
      .DEPTH(STORE_DEPTH)
   ) u_slots (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_en  (cmd.mem_rd),
      .rd_addr(cand_ff[IDX_W-1:0]),
      .rd_data(rd_data)
   );

   always_comb begin
      sts.cand_oor    = (32'(cand_ff) >= 32'(STORE_DEPTH));
      sts.cand_is_one = (cand_ff == SLOT_W'(1));
      sts.cand_odd    = cand_ff[0];
      sts.clear_last  = (cand_ff[IDX_W-1:0] == IDX_W'(STORE_DEPTH - 1));
      sts.rdata_empty = (rd_data == EMPTY_MARK);
      sts.rdata_match = (rd_data == key_ff);
      sts.left_empty  = left_empty_ff;
      sts.rd_oor      = (32'(rd_ff) >= 32'(STORE_DEPTH));
      sts.out_busy    = out_valid_ff && !rsp_tready;
      sts.kind        = kind_ff;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_status_ff;
   assign rsp_tdata  = {7'd0, out_empty_ff, out_value_ff, out_idx_ff};

endmodule

/* hw/rtl/abts_ctrl.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// abts_ctrl: controller of the array binary tree store
// Sequences the clearing sweep, the stackless preorder search, the child
// and leaf checks, and the hand-off of each result to the output register.
// ---------------------------------------------------------------------------
module abts_ctrl import abts_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  abts_sts_type sts,
   output abts_cmd_type cmd
);

   localparam logic [3:0] S_CLEAR     = 4'd0;
   localparam logic [3:0] S_IDLE      = 4'd1;
   localparam logic [3:0] S_DISPATCH  = 4'd2;
   localparam logic [3:0] S_SEARCH    = 4'd3;
   localparam logic [3:0] S_CHECK     = 4'd4;
   localparam logic [3:0] S_ASCEND    = 4'd5;
   localparam logic [3:0] S_CHILD_RD  = 4'd6;
   localparam logic [3:0] S_CHILD_CHK = 4'd7;
   localparam logic [3:0] S_DEL_L     = 4'd8;
   localparam logic [3:0] S_DEL_LCHK  = 4'd9;
   localparam logic [3:0] S_DEL_R     = 4'd10;
   localparam logic [3:0] S_DEL_RCHK  = 4'd11;
   localparam logic [3:0] S_READ_RD   = 4'd12;
   localparam logic [3:0] S_READ_CHK  = 4'd13;
   localparam logic [3:0] S_FINISH    = 4'd14;

   logic [3:0] state_ff, state_in;
   logic       right_empty;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_tready  = (state_ff == S_IDLE);
   assign right_empty = sts.cand_oor || sts.rdata_empty;

   always_comb begin
      state_in         = state_ff;
      cmd              = '0;
      cmd.cand_op      = CAND_HOLD;
      cmd.wr_sel       = WR_CLEAR;
      cmd.res_status   = ST_OK;
      cmd.res_idx_sel  = RIDX_ZERO;
      cmd.res_val_sel  = RVAL_EMPTY;
      unique case (state_ff)
         S_CLEAR: begin
            cmd.mem_wr  = 1'b1;
            cmd.wr_sel  = WR_CLEAR;
            cmd.cand_op = CAND_INC;
            if (sts.clear_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.load_item = 1'b1;
               state_in      = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            unique case (sts.kind)
               KIND_SET_ROOT: begin
                  cmd.mem_wr      = 1'b1;
                  cmd.wr_sel      = WR_ROOT;
                  cmd.res_load    = 1'b1;
                  cmd.res_status  = ST_OK;
                  cmd.res_idx_sel = RIDX_ONE;
                  cmd.res_val_sel = RVAL_NEW;
                  state_in        = S_FINISH;
               end
               KIND_READ: begin
                  cmd.cand_op = CAND_READ;
                  state_in    = S_READ_RD;
               end
               default: begin
                  cmd.cand_op = CAND_ROOT;
                  state_in    = S_SEARCH;
               end
            endcase
         end
         S_SEARCH: begin
            if (sts.cand_oor) begin
               state_in = S_ASCEND;
            end else begin
               cmd.mem_rd = 1'b1;
               state_in   = S_CHECK;
            end
         end
         S_CHECK: begin
            priority if (sts.rdata_empty) begin
               state_in = S_ASCEND;
            end else if (sts.rdata_match) begin
               cmd.found_load = 1'b1;
               if (sts.kind == KIND_INSERT) begin
                  cmd.cand_op = CAND_CHILD;
                  state_in    = S_CHILD_RD;
               end else begin
                  cmd.cand_op = CAND_LEFT;
                  state_in    = S_DEL_L;
               end
            end else begin
               cmd.cand_op = CAND_DOUBLE;
               state_in    = S_SEARCH;
            end
         end
         S_ASCEND: begin
            priority if (sts.cand_is_one) begin
               cmd.res_load    = 1'b1;
               cmd.res_status  = ST_NOT_FOUND;
               cmd.res_idx_sel = RIDX_ZERO;
               cmd.res_val_sel = RVAL_EMPTY;
               state_in        = S_FINISH;
            end else if (!sts.cand_odd) begin
               cmd.cand_op = CAND_INC;
               state_in    = S_SEARCH;
            end else begin
               cmd.cand_op = CAND_HALF;
            end
         end
         S_CHILD_RD: begin
            if (sts.cand_oor) begin
               cmd.res_load    = 1'b1;
               cmd.res_status  = ST_NO_ROOM;
               cmd.res_idx_sel = RIDX_FOUND;
               cmd.res_val_sel = RVAL_KEY;
               state_in        = S_FINISH;
            end else begin
               cmd.mem_rd = 1'b1;
               state_in   = S_CHILD_CHK;
            end
         end
         S_CHILD_CHK: begin
            cmd.res_load    = 1'b1;
            cmd.res_idx_sel = RIDX_CAND;
            if (sts.rdata_empty) begin
               cmd.mem_wr      = 1'b1;
               cmd.wr_sel      = WR_CHILD;
               cmd.res_status  = ST_OK;
               cmd.res_val_sel = RVAL_NEW;
            end else begin
               cmd.res_status  = ST_BLOCKED;
               cmd.res_val_sel = RVAL_RDATA;
            end
            state_in = S_FINISH;
         end
         S_DEL_L: begin
            if (sts.cand_oor) begin
               cmd.left_load = 1'b1;
               cmd.cand_op   = CAND_RIGHT;
               state_in      = S_DEL_R;
            end else begin
               cmd.mem_rd = 1'b1;
               state_in   = S_DEL_LCHK;
            end
         end
         S_DEL_LCHK: begin
            cmd.left_load    = 1'b1;
            cmd.left_from_rd = 1'b1;
            cmd.cand_op      = CAND_RIGHT;
            state_in         = S_DEL_R;
         end
         S_DEL_R, S_DEL_RCHK: begin
            if (state_ff == S_DEL_R && !sts.cand_oor) begin
               cmd.mem_rd = 1'b1;
               state_in   = S_DEL_RCHK;
            end else begin
               cmd.res_load    = 1'b1;
               cmd.res_idx_sel = RIDX_FOUND;
               if (sts.left_empty && right_empty) begin
                  cmd.mem_wr      = 1'b1;
                  cmd.wr_sel      = WR_DELETE;
                  cmd.res_status  = ST_OK;
                  cmd.res_val_sel = RVAL_EMPTY;
               end else begin
                  cmd.res_status  = ST_BLOCKED;
                  cmd.res_val_sel = RVAL_KEY;
               end
               state_in = S_FINISH;
            end
         end
         S_READ_RD: begin
            if (sts.rd_oor) begin
               cmd.res_load    = 1'b1;
               cmd.res_status  = ST_NO_ROOM;
               cmd.res_idx_sel = RIDX_READ;
               cmd.res_val_sel = RVAL_EMPTY;
               state_in        = S_FINISH;
            end else begin
               cmd.mem_rd = 1'b1;
               state_in   = S_READ_CHK;
            end
         end
         S_READ_CHK: begin
            cmd.res_load    = 1'b1;
            cmd.res_status  = ST_OK;
            cmd.res_idx_sel = RIDX_READ;
            cmd.res_val_sel = RVAL_RDATA;
            state_in        = S_FINISH;
         end
         S_FINISH: begin
            if (!sts.out_busy) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_CLEAR;
         end
      endcase
   end

endmodule
